FILE: rtl/core/ntpps_pkg.sv
// ----------------------------------------------------------------------------
// ntpps_pkg
// Shared constants and types for the NTP peer statistics update block.
// ----------------------------------------------------------------------------
package ntpps_pkg;

  // Table geometry
  localparam int SLOT_W       = 3;
  localparam int SERVER_SLOTS = 8;

  // Time conversion constants
  localparam logic [31:0] ERA_DELTA    = 32'd2208988800;
  localparam logic [19:0] USEC_PER_SEC = 20'd1000000;

  // Field widths
  localparam int SEC_W   = 32;
  localparam int USEC_W  = 20;
  localparam int FRAC_W  = 32;
  localparam int TS_W    = 52;  // whole microseconds of a 32-bit second count
  localparam int OFS_W   = 32;
  localparam int JIT_W   = 31;
  localparam int REACH_W = 8;

  // Stream widths
  localparam int IN_TDATA_W  = 232;
  localparam int IN_TUSER_W  = 4;
  localparam int OUT_TDATA_W = 112;
  localparam int OUT_TUSER_W = SLOT_W;

  // One table entry; offset sits in the low bits
  typedef struct packed {
    logic               reachable;
    logic               valid;
    logic [REACH_W-1:0] reach;
    logic [JIT_W-1:0]   jitter;
    logic [OFS_W-1:0]   delay;
    logic [OFS_W-1:0]   offset;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

FILE: rtl/core/ntpps_entry_ram.sv
// ----------------------------------------------------------------------------
// ntpps_entry_ram
// Per-slot statistics memory with registered read. A live bit per
// slot, cleared at reset, makes never-written entries read as zero.
// ----------------------------------------------------------------------------
module ntpps_entry_ram (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       rd_en,
  input  logic [ntpps_pkg::SLOT_W-1:0] rd_addr,
  output ntpps_pkg::entry_t          rd_data,
  input  logic                       wr_en,
  input  logic [ntpps_pkg::SLOT_W-1:0] wr_addr,
  input  ntpps_pkg::entry_t          wr_data
);
  import ntpps_pkg::*;

  entry_t                  entry_mem [SERVER_SLOTS];
  entry_t                  rd_q_r;
  logic                    rd_live_r;
  logic [SERVER_SLOTS-1:0] live_r;

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      entry_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q_r <= entry_mem[rd_addr];
    end
  end

  // Track which entries hold written data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      live_r    <= '0;
      rd_live_r <= 1'b0;
    end else begin
      if (wr_en) begin
        live_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_live_r <= live_r[rd_addr];
      end
    end
  end

  // Unwritten entries read as zero
  assign rd_data = rd_live_r ? rd_q_r : '0;

endmodule

FILE: rtl/core/ntp_peer_statistics_update.sv
// ----------------------------------------------------------------------------
// ntp_peer_statistics_update
// Per-peer NTP statistics: offset, round-trip delay, jitter and reach,
// updated by read-modify-write of one table entry per poll result.
// ----------------------------------------------------------------------------
// Sequence: each transaction reads its entry from the RAM as it is taken,
// steps through the MUL, SUM, DIF, ACC, OFS and MAG states and writes an
// in-range entry back in ST_WB as the output register loads; a stalled
// output holds the write-back stage. No new transaction until ST_IDLE.
// Reset: synchronous, active low; clears the control state and marks all
// eight table entries as zero at once (no clearing pass).
// ----------------------------------------------------------------------------
module ntp_peer_statistics_update (
  input  logic                              clk,
  input  logic                              rst_n,
  // tdata: send_sec, send_usec, recv_sec, recv_usec, server_rx_sec,
  //        server_rx_frac, server_tx_sec, server_tx_frac
  input  logic [ntpps_pkg::IN_TDATA_W-1:0]  in_tdata,
  // tuser: server_slot, query_ok
  input  logic [ntpps_pkg::IN_TUSER_W-1:0]  in_tuser,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // tdata: clock_offset, path_delay, jitter_avg, reach_bits, is_valid,
  //        is_reachable, zero pad
  output logic [ntpps_pkg::OUT_TDATA_W-1:0] out_tdata,
  // tuser: slot_out
  output logic [ntpps_pkg::OUT_TUSER_W-1:0] out_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready
);
  import ntpps_pkg::*;

  typedef enum logic [7:0] {
    ST_IDLE = 8'b0000_0001,
    ST_MUL  = 8'b0000_0010,
    ST_SUM  = 8'b0000_0100,
    ST_DIF  = 8'b0000_1000,
    ST_ACC  = 8'b0001_0000,
    ST_OFS  = 8'b0010_0000,
    ST_MAG  = 8'b0100_0000,
    ST_WB   = 8'b1000_0000
  } state_t;

  localparam logic [SLOT_W:0] SLOT_LIMIT = (SLOT_W + 1)'(SERVER_SLOTS);
  localparam int DIF_W = TS_W + 1;
  localparam int ACC_W = TS_W + 3;

  state_t state_r, state_nxt;

  // Captured transaction
  logic [SLOT_W-1:0] slot_r;
  logic              ok_r;
  logic              in_range_r;
  logic [SEC_W-1:0]  send_sec_r, recv_sec_r, rx_unix_r, tx_unix_r;
  logic [USEC_W-1:0] send_usec_r, recv_usec_r;
  logic [FRAC_W-1:0] rx_frac_r, tx_frac_r;

  // Arithmetic stages
  logic [TS_W-1:0]   p1_r, p2_r, p3_r, p4_r;
  logic [TS_W-1:0]   pf2_r, pf3_r;
  logic [TS_W-1:0]   t1_r, t2_r, t3_r, t4_r;
  logic [DIF_W-1:0]  a_r, b_r;
  logic [OFS_W-1:0]  d1_r, d2_r;
  logic [ACC_W-1:0]  s_r;
  logic [OFS_W-1:0]  dly_r, new_off_r, mag_r;
  logic [JIT_W+2:0]  j7_r;
  entry_t            old_r;

  logic [OFS_W-1:0]  off_diff;
  logic [OFS_W:0]    off_round;
  logic [JIT_W+3:0]  jit_sum;
  logic [REACH_W-1:0] reach_fail;
  entry_t            new_entry;
  entry_t            rd_entry;
  entry_t            out_entry_r;
  logic              out_valid_r;
  logic [SLOT_W-1:0] out_slot_r;
  logic              in_fire, out_load, wr_en;

  assign in_tready = (state_r == ST_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign out_load  = (state_r == ST_WB) && (!out_valid_r || out_tready);
  assign wr_en     = out_load && in_range_r;

  // Entry store
  ntpps_entry_ram u_ram (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (in_fire),
    .rd_addr (in_tuser[SLOT_W-1:0]),
    .rd_data (rd_entry),
    .wr_en   (wr_en),
    .wr_addr (slot_r),
    .wr_data (new_entry)
  );

  // Sequence one transaction through the arithmetic steps
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_fire) state_nxt = ST_MUL;
      ST_MUL:  state_nxt = ST_SUM;
      ST_SUM:  state_nxt = ST_DIF;
      ST_DIF:  state_nxt = ST_ACC;
      ST_ACC:  state_nxt = ST_OFS;
      ST_OFS:  state_nxt = ST_MAG;
      ST_MAG:  state_nxt = ST_WB;
      ST_WB:   if (out_load) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Capture the transaction; move the NTP seconds to the Unix era
  always_ff @(posedge clk) begin
    if (in_fire) begin
      slot_r      <= in_tuser[SLOT_W-1:0];
      ok_r        <= in_tuser[SLOT_W];
      in_range_r  <= ({1'b0, in_tuser[SLOT_W-1:0]} < SLOT_LIMIT);
      send_sec_r  <= in_tdata[31:0];
      send_usec_r <= in_tdata[51:32];
      recv_sec_r  <= in_tdata[83:52];
      recv_usec_r <= in_tdata[103:84];
      rx_unix_r   <= in_tdata[135:104] - ERA_DELTA;
      rx_frac_r   <= in_tdata[167:136];
      tx_unix_r   <= in_tdata[199:168] - ERA_DELTA;
      tx_frac_r   <= in_tdata[231:200];
    end
  end

  // Scale seconds and fractions to microseconds; latch the old entry
  always_ff @(posedge clk) begin
    if (state_r == ST_MUL) begin
      p1_r  <= TS_W'(send_sec_r) * TS_W'(USEC_PER_SEC);
      p4_r  <= TS_W'(recv_sec_r) * TS_W'(USEC_PER_SEC);
      p2_r  <= TS_W'(rx_unix_r) * TS_W'(USEC_PER_SEC);
      p3_r  <= TS_W'(tx_unix_r) * TS_W'(USEC_PER_SEC);
      pf2_r <= TS_W'(rx_frac_r) * TS_W'(USEC_PER_SEC);
      pf3_r <= TS_W'(tx_frac_r) * TS_W'(USEC_PER_SEC);
      old_r <= rd_entry;
    end
  end

  // Form the four timestamps in whole microseconds
  always_ff @(posedge clk) begin
    if (state_r == ST_SUM) begin
      t1_r <= p1_r + TS_W'(send_usec_r);
      t4_r <= p4_r + TS_W'(recv_usec_r);
      t2_r <= p2_r + TS_W'(pf2_r[TS_W-1:FRAC_W]);
      t3_r <= p3_r + TS_W'(pf3_r[TS_W-1:FRAC_W]);
    end
  end

  // Pairwise differences and seven times the old jitter; delay only needs the low word
  always_ff @(posedge clk) begin
    if (state_r == ST_DIF) begin
      a_r  <= {1'b0, t2_r} - {1'b0, t1_r};
      b_r  <= {1'b0, t3_r} - {1'b0, t4_r};
      d1_r <= t4_r[OFS_W-1:0] - t1_r[OFS_W-1:0];
      d2_r <= t3_r[OFS_W-1:0] - t2_r[OFS_W-1:0];
      j7_r <= {old_r.jitter, 3'b000} - (JIT_W + 3)'(old_r.jitter);
    end
  end

  // Full-width offset sum and delay
  always_ff @(posedge clk) begin
    if (state_r == ST_ACC) begin
      s_r   <= {{2{a_r[DIF_W-1]}}, a_r} + {{2{b_r[DIF_W-1]}}, b_r};
      dly_r <= d1_r - d2_r;
    end
  end

  // Halve toward zero: add one before the shift when the sum is negative
  assign off_round = s_r[OFS_W:0] + (OFS_W + 1)'(s_r[ACC_W-1]);

  always_ff @(posedge clk) begin
    if (state_r == ST_OFS) begin
      new_off_r <= off_round[OFS_W:1];
    end
  end

  // Magnitude of the offset change in 32 bits
  assign off_diff = new_off_r - old_r.offset;

  always_ff @(posedge clk) begin
    if (state_r == ST_MAG) begin
      mag_r <= off_diff[OFS_W-1] ? (~off_diff + OFS_W'(1'b1)) : off_diff;
    end
  end

  // Build the updated entry
  assign jit_sum    = (JIT_W + 4)'(j7_r) + (JIT_W + 4)'(mag_r);
  assign reach_fail = {old_r.reach[REACH_W-2:0], 1'b0};

  always_comb begin
    new_entry = old_r;
    if (ok_r) begin
      new_entry.offset    = new_off_r;
      new_entry.delay     = dly_r;
      new_entry.jitter    = old_r.valid ? jit_sum[JIT_W+2:3] : '0;
      new_entry.reach     = {old_r.reach[REACH_W-2:0], 1'b1};
      new_entry.valid     = 1'b1;
      new_entry.reachable = 1'b1;
    end else begin
      new_entry.reach     = reach_fail;
      new_entry.reachable = old_r.reachable && (reach_fail != '0);
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_slot_r  <= slot_r;
      out_entry_r <= in_range_r ? new_entry : '0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_slot_r;
  assign out_tdata  = {(OUT_TDATA_W - ENTRY_W)'(0), out_entry_r};

endmodule

FILE: rtl/core/ntpps_checker.sv
// ----------------------------------------------------------------------------
// ntpps_checker
// Port-level checks for the NTP peer statistics update block.
// ----------------------------------------------------------------------------
module ntpps_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_tvalid,
  input logic                              in_tready,
  input logic [ntpps_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic [ntpps_pkg::OUT_TUSER_W-1:0] out_tuser,
  input logic                              out_tvalid,
  input logic                              out_tready
);

  // Reset leaves the block ready with nothing to deliver
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> in_tready && !out_tvalid)
    else $error("block not idle after reset");

  // One transaction in flight: ready drops right after an input transaction
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second transaction taken while one is in flight");

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=>
      out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

  // Nonzero reach implies reachable (reach_bits 102:95, is_reachable 104)
  a_reach_mark: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[102:95] != 8'd0) |-> out_tdata[104])
    else $error("reach bits set on an unreachable entry");

  // An entry never measured carries no offset, jitter or reachable mark
  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[103] |->
      !out_tdata[104] && (out_tdata[31:0] == 32'd0) && (out_tdata[94:64] == 31'd0))
    else $error("unmeasured entry carries statistics");

endmodule

bind ntp_peer_statistics_update ntpps_checker u_ntpps_checker (.*);
